// ===== sv/binary_to_radix_ascii_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix ASCII converter
// Concurrent checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_RADIX_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_RADIX_ASCII_TOP_DEFINES_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define B2RA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define B2RA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/b2ra_pkg.sv =====
// ----------------------------------------------------------------------------
// b2ra_pkg
// Shared constants and helper functions of the radix ASCII converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2ra_pkg;

    // Default sizes of the converter.
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_DIGITS_DEF  = 64;

    // Fixed field widths.
    localparam int IN_DATA_W  = 64;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int COUNT_W    = 7;
    localparam int OUT_DATA_W = 16;

    // Dividend bits consumed by the shared divider in one cycle.
    localparam int BITS_PER_STEP = 8;

    // Radix register limits and reset value.
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // ASCII anchors for the digit characters.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;
    localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    // Clamp a written radix into the supported range.
    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] wr);
        logic [RADIX_W-1:0] r;
        r = wr;
        if (wr < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (wr > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    // Map one digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE) begin
            c = CHAR_W'(d - DIGIT_TEN) + ASCII_A;
        end else begin
            c = CHAR_W'(d) + ASCII_ZERO;
        end
        return c;
    endfunction

endpackage

// ===== sv/binary_to_radix_ascii_top.sv =====
// Usage:
// A value enters on the slave stream (i_s_axis_*), tdata holding the unsigned
// number. Only its low VALUE_WIDTH bits are converted. The master stream
// (o_m_axis_*) then returns one transaction per digit, most significant digit
// first; tlast marks the final digit, which also carries the digit count.
// The radix is written through the cfg channel, clamped to 2..36 and reset to 10;
// the user must write it only while the block is idle, which the block does not enforce.
// Timing: a single restoring divider retires 8 dividend bits per cycle and runs
// the whole padded value through it once for each digit. Every digit is then
// read back from the digit memory in ST_READ and shown in ST_OUT until the
// receiver takes it.
// The slave side is ready only while no value is in work.
// A synchronous active-low reset returns the block to idle, drops all valid
// outputs and restores radix 10. When the receiver holds tready low, the
// current digit stays on the master port unchanged until it is taken.
`timescale 1ns / 1ps

`include "binary_to_radix_ascii_top_defines.svh"

// ----------------------------------------------------------------------------
// binary_to_radix_ascii_top
// Converts an unsigned integer into ASCII digits in a programmable radix.
// ----------------------------------------------------------------------------
module binary_to_radix_ascii_top
    import b2ra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [RADIX_W-1:0]    i_cfg_data,     // [5:0] radix
    // Slave stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata, // [63:0] value
    // Master stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata, // [6:0] digit_char, [13:7] digit_count,
                                                  // [15:14] zero
    output logic                  o_m_axis_tlast
);

    // Derived sizes.
    localparam int STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W   = STEPS * BITS_PER_STEP;
    localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int REM_W   = RADIX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state_e;

    t_state_e            r_state, n_state;
    logic [RADIX_W-1:0]  r_radix, n_radix;
    logic [PAD_W-1:0]    r_quot, n_quot;
    logic [RADIX_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RADIX_W-1:0]  r_rd_data;

    logic [RADIX_W-1:0]  mem_digits [MAX_DIGITS];

    logic [REM_W-1:0]    d_rem;
    logic [PAD_W-1:0]    d_quot;
    logic                digit_done;
    logic                digit_wr;
    logic                in_xfer;
    logic                out_xfer;
    logic                last_digit;

    // Shared divider: restoring division over BITS_PER_STEP dividend bits.
    always_comb begin
        d_rem  = REM_W'(r_rem);
        d_quot = r_quot;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            d_rem  = {d_rem[RADIX_W-1:0], d_quot[PAD_W-1]};
            d_quot = {d_quot[PAD_W-2:0], 1'b0};
            if (d_rem >= REM_W'(r_radix)) begin
                d_rem     = d_rem - REM_W'(r_radix);
                d_quot[0] = 1'b1;
            end
        end
    end

    // Handshake terms.
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer        = o_m_axis_tvalid && i_m_axis_tready;
    assign last_digit      = (r_rd_ptr == '0);
    assign digit_done      = (r_step == STEP_W'(STEPS - 1));
    assign digit_wr        = (r_state == ST_DIV) && digit_done;

    // Sequencer next-state logic.
    always_comb begin
        n_state  = r_state;
        n_radix  = r_radix;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_rd_ptr = r_rd_ptr;

        if (i_cfg_valid && o_cfg_ready) begin
            n_radix = sat_radix(i_cfg_data);
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_quot  = PAD_W'(i_s_axis_tdata[VALUE_WIDTH-1:0]);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quot = d_quot;
                n_rem  = d_rem[RADIX_W-1:0];
                n_step = r_step + 1'b1;
                if (digit_done) begin
                    n_rem  = '0;
                    n_step = '0;
                    n_cnt  = r_cnt + 1'b1;
                    if ((d_quot == '0) || (r_cnt == CNT_W'(MAX_DIGITS - 1))) begin
                        n_rd_ptr = r_cnt[ADDR_W-1:0];
                        n_state  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_xfer) begin
                    if (last_digit) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_ptr = r_rd_ptr - 1'b1;
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_radix  <= RADIX_RESET;
            r_quot   <= '0;
            r_rem    <= '0;
            r_step   <= '0;
            r_cnt    <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_state  <= n_state;
            r_radix  <= n_radix;
            r_quot   <= n_quot;
            r_rem    <= n_rem;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Digit memory: written least significant first, read back in reverse.
    always_ff @(posedge i_clk) begin
        if (digit_wr) begin
            mem_digits[r_cnt[ADDR_W-1:0]] <= d_rem[RADIX_W-1:0];
        end
        r_rd_data <= mem_digits[r_rd_ptr];
    end

    // Output payload.
    assign o_m_axis_tlast = last_digit;
    assign o_m_axis_tdata = {2'b00,
                             (last_digit ? COUNT_W'(r_cnt) : COUNT_W'(0)),
                             to_ascii(r_rd_data)};

    // Checks.
    `B2RA_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready, "input ready while a digit is shown")
    `B2RA_ASSERT_NOW(a_radix_range, i_clk, i_rst_n, 1'b1, (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX), "radix out of range")
    `B2RA_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_DIGITS)), "bad digit count")
    `B2RA_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, out_xfer && o_m_axis_tlast, !o_m_axis_tvalid && o_s_axis_tready, "no return to idle after last digit")

endmodule

// ===== tb/binary_to_radix_ascii_top_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// binary_to_radix_ascii_top_tb
// Self-checking bench for the radix ASCII converter. A short directed table
// covers zero, the largest value, digit letters and radix saturation. Random
// values follow under several radix settings and handshake idling patterns.
// Every digit transaction is checked against a typed or in-bench conversion.
// ----------------------------------------------------------------------------
module binary_to_radix_ascii_top_tb;
    import b2ra_pkg::*;

    localparam int  RESET_CYCLES   = 12;
    localparam int  SETTLE_CYCLES  = 16;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  PHASE_COUNT    = 8;
    localparam int  PHASE_ITEMS    = 51;
    localparam int  MAX_REPORTS    = 10;
    localparam longint CYCLE_LIMIT = 2000000;

    // One expected digit transaction.
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } t_digit_beat;

    // One row of the directed stimulus table.
    typedef struct {
        bit                 cfg_en;
        logic [RADIX_W-1:0] cfg_raw;
        logic [63:0]        value;
        string              digits;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [RADIX_W-1:0]    i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    t_digit_beat        pending_digits[$];
    t_dir_row           dir_rows[$];
    logic [RADIX_W-1:0] radix_shadow;
    int                 error_count;
    longint             cycle_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_req;

    binary_to_radix_ascii_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Clamp a written radix the way the register does.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (r < 6'd2) begin
            r = 6'd2;
        end else if (r > 6'd36) begin
            r = 6'd36;
        end
        return r;
    endfunction

    // Convert one value in the current radix and queue its digit transactions.
    function automatic void predict_digits(input logic [63:0] value);
        logic [63:0]        quot;
        logic [RADIX_W-1:0] digs[64];
        logic [RADIX_W-1:0] d;
        t_digit_beat        beat;
        int                 n;
        int                 k;
        quot = value;
        n    = 0;
        if (quot == 64'd0) begin
            digs[0] = '0;
            n       = 1;
        end else begin
            while (quot != 64'd0 && n < 64) begin
                digs[n] = RADIX_W'(quot % radix_shadow);
                quot    = quot / radix_shadow;
                n++;
            end
        end
        // Digits were found least significant first; emit in reverse.
        for (k = n - 1; k >= 0; k--) begin
            d          = digs[k];
            beat.ch    = (d > 6'd9) ? CHAR_W'(d - 6'd10) + 7'd65 : CHAR_W'(d) + 7'd48;
            beat.last  = (k == 0);
            beat.count = (k == 0) ? COUNT_W'(n) : '0;
            pending_digits.push_back(beat);
        end
    endfunction

    // Queue a digit string typed directly into the directed table.
    function automatic void push_typed(input string s);
        t_digit_beat beat;
        byte         c;
        int          i;
        for (i = 0; i < s.len(); i++) begin
            c          = s[i];
            beat.ch    = c[6:0];
            beat.last  = (i == s.len() - 1);
            beat.count = beat.last ? COUNT_W'(s.len()) : '0;
            pending_digits.push_back(beat);
        end
    endfunction

    // Random value: mostly random bit lengths, with radix powers and all ones.
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        logic [63:0] p;
        int          nbits;
        int          k;
        int          j;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '1;
            1, 2: begin
                // Powers of the radix and one below them sit on digit count edges.
                p = 64'd1;
                k = $urandom_range(1, 64);
                for (j = 0; j < k; j++) begin
                    if (p > (64'hFFFF_FFFF_FFFF_FFFF / radix_shadow)) break;
                    p = p * radix_shadow;
                end
                v = p - 64'($urandom_range(0, 1));
            end
            default: begin
                nbits = $urandom_range(0, 64);
                v     = (nbits == 0) ? 64'd0 : (v >> (64 - nbits));
            end
        endcase
        return v;
    endfunction

    // Offer one value on the slave stream and wait for its transaction.
    task automatic send_value(input logic [63:0] value);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = value;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Let the block drain, then write the radix register.
    task automatic write_radix(input logic [RADIX_W-1:0] raw);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        radix_shadow = clamp_radix(raw);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: random tready per the current stall rate, with long hold-offs.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req        = 1'b0;
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Check each digit transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_digit_beat exp_beat;
        t_digit_beat got_beat;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got_beat.ch    = o_m_axis_tdata[6:0];
            got_beat.last  = o_m_axis_tlast;
            got_beat.count = o_m_axis_tdata[13:7];
            if (pending_digits.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected digit: char %0d last %0b count %0d",
                             got_beat.ch, got_beat.last, got_beat.count);
                end
            end else begin
                exp_beat = pending_digits.pop_front();
                if (got_beat !== exp_beat) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Digit mismatch: exp char %0d last %0b count %0d, ",
                                 exp_beat.ch, exp_beat.last, exp_beat.count,
                                 "got char %0d last %0b count %0d",
                                 got_beat.ch, got_beat.last, got_beat.count);
                    end
                end
            end
        end
    end

    // Cycle counter with a hard timeout.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial begin
        logic [RADIX_W-1:0] phase_raw[PHASE_COUNT];
        int                 ph;
        int                 it;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        radix_shadow    = 6'd10;
        error_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b0;

        // Directed table; an empty digit string means the conversion is computed.
        dir_rows.push_back('{1'b0, 6'd0,  64'd0,                    "0"});
        dir_rows.push_back('{1'b0, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF,  "18446744073709551615"});
        dir_rows.push_back('{1'b0, 6'd0,  64'd9,                    "9"});
        dir_rows.push_back('{1'b0, 6'd0,  64'd10,                   "10"});
        dir_rows.push_back('{1'b0, 6'd0,  64'd1,                    "1"});
        dir_rows.push_back('{1'b0, 6'd0,  64'h8000_0000_0000_0000,  "9223372036854775808"});
        dir_rows.push_back('{1'b1, 6'd16, 64'hFFFF_FFFF_FFFF_FFFF,  "FFFFFFFFFFFFFFFF"});
        dir_rows.push_back('{1'b0, 6'd0,  64'h0123_4567_89AB_CDEF,  "123456789ABCDEF"});
        dir_rows.push_back('{1'b1, 6'd0,  64'd5,                    "101"});
        dir_rows.push_back('{1'b0, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF,  ""});
        dir_rows.push_back('{1'b0, 6'd0,  64'd0,                    "0"});
        dir_rows.push_back('{1'b1, 6'd1,  64'h8000_0000_0000_0000,  ""});
        dir_rows.push_back('{1'b1, 6'd63, 64'd35,                   "Z"});
        dir_rows.push_back('{1'b0, 6'd0,  64'd36,                   "10"});
        dir_rows.push_back('{1'b0, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF,  ""});
        dir_rows.push_back('{1'b1, 6'd37, 64'd1295,                 "ZZ"});
        dir_rows.push_back('{1'b1, 6'd36, 64'd0,                    "0"});
        dir_rows.push_back('{1'b1, 6'd11, 64'd10,                   "A"});
        dir_rows.push_back('{1'b1, 6'd35, 64'd34,                   "Y"});
        dir_rows.push_back('{1'b1, 6'd2,  64'd1,                    "1"});
        dir_rows.push_back('{1'b1, 6'd8,  64'hFFFF_FFFF_FFFF_FFFF,  "1777777777777777777777"});
        dir_rows.push_back('{1'b1, 6'd10, 64'd12345678901234567890, "12345678901234567890"});

        // Synchronous reset, released on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_en) begin
                write_radix(dir_rows[i].cfg_raw);
            end
            send_value(dir_rows[i].value);
            if (dir_rows[i].digits.len() == 0) begin
                predict_digits(dir_rows[i].value);
            end else begin
                push_typed(dir_rows[i].digits);
            end
        end

        // Random phases: fixed radix settings first, then random raw writes.
        phase_raw[0] = 6'd10;
        phase_raw[1] = 6'd36;
        phase_raw[2] = 6'd2;
        phase_raw[3] = 6'd16;
        phase_raw[4] = 6'd63;
        phase_raw[5] = 6'd0;
        phase_raw[6] = 6'($urandom_range(0, 63));
        phase_raw[7] = 6'($urandom_range(0, 63));
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            write_radix(phase_raw[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // Long receiver hold-off while values keep coming.
            if (ph == 0 || ph == 5) begin
                hold_req = 1'b1;
            end
            for (it = 0; it < PHASE_ITEMS; it++) begin
                send_value(rand_value());
                predict_digits(i_s_axis_tdata);
            end
        end

        // Drain and report.
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_digits.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
